FILE: hdl/dbbcc_pkg.sv
// Shared widths, register codes and reset values for the climate controller.
`default_nettype none

package dbbcc_pkg;

    // Field widths.
    localparam int TEMP_W     = 15;
    localparam int HUMID_W    = 14;
    localparam int FRAC_W     = 16;
    localparam int LOCK_W     = 8;
    localparam int THR_W      = 17;
    localparam int PROD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_ENABLE   = 3'd0,
        REG_TEMP_TARGET   = 3'd1,
        REG_HUMID_ENABLE  = 3'd2,
        REG_HUMID_TARGET  = 3'd3,
        REG_BAND_ON_FRAC  = 3'd4,
        REG_BAND_OFF_FRAC = 3'd5,
        REG_LOCKOUT_TICKS = 3'd6
    } cfg_index_t;

    // Configuration reset values.
    localparam logic                    RST_TEMP_ENABLE   = 1'b1;
    localparam logic signed [TEMP_W-1:0] RST_TEMP_TARGET  = 15'sd2800;
    localparam logic                    RST_HUMID_ENABLE  = 1'b0;
    localparam logic [HUMID_W-1:0]      RST_HUMID_TARGET  = 14'd5000;
    localparam logic [FRAC_W-1:0]       RST_BAND_ON_FRAC  = 16'd1835;
    localparam logic [FRAC_W-1:0]       RST_BAND_OFF_FRAC = 16'd1114;
    localparam logic [LOCK_W-1:0]       RST_LOCKOUT_TICKS = 8'd10;

endpackage

`default_nettype wire

FILE: hdl/dbbcc_if.sv
// Request channels of the climate controller: samples, results and register writes.
`default_nettype none

interface dbbcc_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dbbcc_pkg::TEMP_W-1:0]    temp_sample;
    logic        [dbbcc_pkg::HUMID_W-1:0]   humid_sample;
    logic                                   sensor_fault;

    modport source (output valid, output temp_sample, output humid_sample,
                    output sensor_fault, input ready);
    modport sink   (input valid, input temp_sample, input humid_sample,
                    input sensor_fault, output ready);
endinterface

interface dbbcc_result_if;
    logic valid;
    logic ready;
    logic heater_on;
    logic cooler_on;
    logic ventilator_on;
    logic humidifier_on;

    modport source (output valid, output heater_on, output cooler_on,
                    output ventilator_on, output humidifier_on, input ready);
    modport sink   (input valid, input heater_on, input cooler_on,
                    input ventilator_on, input humidifier_on, output ready);
endinterface

interface dbbcc_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [dbbcc_pkg::CFG_IDX_W-1:0]        index;
    logic [dbbcc_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/dual_bang_bang_climate_controller.sv
// A sample request is accepted into the sample register and passes to the drive register,
// where its result request is valid. Throughput: one sample per cycle while results are
// taken; the sample register and the drive register form a two-stage pipeline, and the
// drive register doubles as the result register.
// Reset: all drives off, all lockout counters zero, registers at their documented defaults.
// Register writes are always ready; a write to an unused index is dropped.
`default_nettype none

module dual_bang_bang_climate_controller (
    input  wire            clk,
    input  wire            rst_n,
    dbbcc_sample_if.sink   sample_in,
    dbbcc_result_if.source result_out,
    dbbcc_cfg_if.sink      cfg
);
    import dbbcc_pkg::*;

    // Configuration registers.
    logic                     temp_enable_reg;
    logic signed [TEMP_W-1:0] temp_target_reg;
    logic                     humid_enable_reg;
    logic [HUMID_W-1:0]       humid_target_reg;
    logic [FRAC_W-1:0]        band_on_frac_reg;
    logic [FRAC_W-1:0]        band_off_frac_reg;
    logic [LOCK_W-1:0]        lockout_ticks_reg;

    // Band products, target times fraction.
    logic signed [PROD_W-1:0] temp_on_prod_reg;
    logic signed [PROD_W-1:0] temp_off_prod_reg;
    logic signed [PROD_W-1:0] humid_on_prod_reg;
    logic signed [PROD_W-1:0] humid_off_prod_reg;
    logic signed [PROD_W-1:0] temp_on_prod_next;
    logic signed [PROD_W-1:0] temp_off_prod_next;
    logic signed [PROD_W-1:0] humid_on_prod_next;
    logic signed [PROD_W-1:0] humid_off_prod_next;

    // Sample stage.
    logic                     s1_valid_reg;
    logic signed [TEMP_W-1:0] s1_temp_reg;
    logic [HUMID_W-1:0]       s1_humid_reg;
    logic                     s1_fault_reg;
    logic                     s1_fire;
    logic                     out_adv;

    // Controller state; the drive bits are also the result payload.
    logic                     out_valid_reg;
    logic                     heater_reg;
    logic                     cooler_reg;
    logic                     vent_reg;
    logic                     humidifier_reg;
    logic [LOCK_W-1:0]        heater_lock_reg;
    logic [LOCK_W-1:0]        cooler_lock_reg;
    logic [LOCK_W-1:0]        vent_lock_reg;
    logic [LOCK_W-1:0]        humidifier_lock_reg;
    logic                     heater_next;
    logic                     cooler_next;
    logic                     vent_next;
    logic                     humidifier_next;
    logic [LOCK_W-1:0]        heater_lock_next;
    logic [LOCK_W-1:0]        cooler_lock_next;
    logic [LOCK_W-1:0]        vent_lock_next;
    logic [LOCK_W-1:0]        humidifier_lock_next;

    // Upper threshold: floor(target * (65536 + f) / 65536).
    function automatic logic signed [THR_W-1:0] thr_high(
        input logic signed [TEMP_W-1:0] tgt,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] sh;
        sh = prod >>> 16;
        return THR_W'(tgt) + THR_W'(sh);
    endfunction

    // Lower threshold: floor(target * (65536 - f) / 65536).
    function automatic logic signed [THR_W-1:0] thr_low(
        input logic signed [TEMP_W-1:0] tgt,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] sh;
        sh = (-prod) >>> 16;
        return THR_W'(tgt) + THR_W'(sh);
    endfunction

    // Register writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_enable_reg   <= RST_TEMP_ENABLE;
            temp_target_reg   <= RST_TEMP_TARGET;
            humid_enable_reg  <= RST_HUMID_ENABLE;
            humid_target_reg  <= RST_HUMID_TARGET;
            band_on_frac_reg  <= RST_BAND_ON_FRAC;
            band_off_frac_reg <= RST_BAND_OFF_FRAC;
            lockout_ticks_reg <= RST_LOCKOUT_TICKS;
        end
        else if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                REG_TEMP_ENABLE:   temp_enable_reg   <= cfg.data[0];
                REG_TEMP_TARGET:   temp_target_reg   <= signed'(cfg.data[TEMP_W-1:0]);
                REG_HUMID_ENABLE:  humid_enable_reg  <= cfg.data[0];
                REG_HUMID_TARGET:  humid_target_reg  <= cfg.data[HUMID_W-1:0];
                REG_BAND_ON_FRAC:  band_on_frac_reg  <= cfg.data[FRAC_W-1:0];
                REG_BAND_OFF_FRAC: band_off_frac_reg <= cfg.data[FRAC_W-1:0];
                REG_LOCKOUT_TICKS: lockout_ticks_reg <= cfg.data[LOCK_W-1:0];
                default:           ;
            endcase
        end
    end

    // Band products are refreshed every cycle from the registers.
    always_comb
    begin
        logic signed [FRAC_W:0]  on_s;
        logic signed [FRAC_W:0]  off_s;
        logic signed [HUMID_W:0] hg_s;
        on_s  = signed'({1'b0, band_on_frac_reg});
        off_s = signed'({1'b0, band_off_frac_reg});
        hg_s  = signed'({1'b0, humid_target_reg});
        temp_on_prod_next   = PROD_W'(temp_target_reg) * PROD_W'(on_s);
        temp_off_prod_next  = PROD_W'(temp_target_reg) * PROD_W'(off_s);
        humid_on_prod_next  = PROD_W'(hg_s) * PROD_W'(on_s);
        humid_off_prod_next = PROD_W'(hg_s) * PROD_W'(off_s);
    end

    always_ff @(posedge clk)
    begin
        temp_on_prod_reg   <= temp_on_prod_next;
        temp_off_prod_reg  <= temp_off_prod_next;
        humid_on_prod_reg  <= humid_on_prod_next;
        humid_off_prod_reg <= humid_off_prod_next;
    end

    // Pipeline handshake.
    assign out_adv         = !out_valid_reg || result_out.ready;
    assign s1_fire         = s1_valid_reg && out_adv;
    assign sample_in.ready = !s1_valid_reg || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_in.ready)
        begin
            s1_valid_reg <= sample_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            s1_temp_reg  <= sample_in.temp_sample;
            s1_humid_reg <= sample_in.humid_sample;
            s1_fault_reg <= sample_in.sensor_fault;
        end
    end

    // Hysteresis decisions for both loops, then lockout countdown.
    always_comb
    begin
        logic signed [THR_W-1:0]   t;
        logic signed [THR_W-1:0]   h;
        logic signed [TEMP_W-1:0]  hg;
        logic                      hd;
        logic                      cd;
        logic                      vd;
        logic                      ud;
        logic [LOCK_W-1:0]         hl;
        logic [LOCK_W-1:0]         cl;
        logic [LOCK_W-1:0]         vl;
        logic [LOCK_W-1:0]         ul;
        t  = THR_W'(s1_temp_reg);
        h  = THR_W'(signed'({1'b0, s1_humid_reg}));
        hg = signed'({1'b0, humid_target_reg});
        hd = heater_reg;
        cd = cooler_reg;
        vd = vent_reg;
        ud = humidifier_reg;
        hl = heater_lock_reg;
        cl = cooler_lock_reg;
        vl = vent_lock_reg;
        ul = humidifier_lock_reg;

        // Heater and cooler loop.
        if (!temp_enable_reg || s1_fault_reg)
        begin
            hd = 1'b0;
            cd = 1'b0;
        end
        else
        begin
            if (t > thr_low(temp_target_reg, temp_off_prod_reg) && hd)
            begin
                hd = 1'b0;
                cl = lockout_ticks_reg;
            end
            if (t < thr_high(temp_target_reg, temp_off_prod_reg) && cd)
            begin
                cd = 1'b0;
                hl = lockout_ticks_reg;
            end
            if (t > thr_high(temp_target_reg, temp_on_prod_reg) && cl == '0)
            begin
                cd = 1'b1;
            end
            if (t < thr_low(temp_target_reg, temp_on_prod_reg) && hl == '0)
            begin
                hd = 1'b1;
            end
        end

        // Ventilator and humidifier loop.
        if (!humid_enable_reg || s1_fault_reg)
        begin
            vd = 1'b0;
            ud = 1'b0;
        end
        else
        begin
            if (h < thr_low(hg, humid_off_prod_reg) && vd)
            begin
                vd = 1'b0;
                ul = lockout_ticks_reg;
            end
            if (h > thr_high(hg, humid_off_prod_reg) && ud)
            begin
                ud = 1'b0;
                vl = lockout_ticks_reg;
            end
            if (h > thr_high(hg, humid_on_prod_reg) && vl == '0)
            begin
                vd = 1'b1;
            end
            if (h < thr_low(hg, humid_on_prod_reg) && ul == '0)
            begin
                ud = 1'b1;
            end
        end

        heater_next          = hd;
        cooler_next          = cd;
        vent_next            = vd;
        humidifier_next      = ud;
        heater_lock_next     = (hl != '0) ? hl - 1'b1 : hl;
        cooler_lock_next     = (cl != '0) ? cl - 1'b1 : cl;
        vent_lock_next       = (vl != '0) ? vl - 1'b1 : vl;
        humidifier_lock_next = (ul != '0) ? ul - 1'b1 : ul;
    end

    // Controller state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg       <= 1'b0;
            heater_reg          <= 1'b0;
            cooler_reg          <= 1'b0;
            vent_reg            <= 1'b0;
            humidifier_reg      <= 1'b0;
            heater_lock_reg     <= '0;
            cooler_lock_reg     <= '0;
            vent_lock_reg       <= '0;
            humidifier_lock_reg <= '0;
        end
        else
        begin
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                heater_reg          <= heater_next;
                cooler_reg          <= cooler_next;
                vent_reg            <= vent_next;
                humidifier_reg      <= humidifier_next;
                heater_lock_reg     <= heater_lock_next;
                cooler_lock_reg     <= cooler_lock_next;
                vent_lock_reg       <= vent_lock_next;
                humidifier_lock_reg <= humidifier_lock_next;
            end
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.heater_on     = heater_reg;
    assign result_out.cooler_on     = cooler_reg;
    assign result_out.ventilator_on = vent_reg;
    assign result_out.humidifier_on = humidifier_reg;

`ifndef SYNTHESIS
    // A faulty sample forces every drive off.
    a_fault_all_off: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_fault_reg |=> !heater_reg && !cooler_reg && !vent_reg && !humidifier_reg)
        else $error("drive left on after a sensor fault");

    // Lockout counters move only when a sample is processed.
    a_lock_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(heater_lock_reg) && $stable(cooler_lock_reg)
                     && $stable(vent_lock_reg) && $stable(humidifier_lock_reg))
        else $error("lockout counter changed without a sample");

    // A locked-out heater cannot switch on while a reload keeps the lockout nonzero.
    a_heater_locked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !heater_reg && heater_lock_reg != '0 && lockout_ticks_reg != '0
        |=> !heater_reg)
        else $error("heater switched on during lockout");

    // A locked-out ventilator cannot switch on while a reload keeps the lockout nonzero.
    a_vent_locked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !vent_reg && vent_lock_reg != '0 && lockout_ticks_reg != '0
        |=> !vent_reg)
        else $error("ventilator switched on during lockout");

    // Result valid follows a processed sample.
    a_result_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("processed sample gave no result");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_dual_bang_bang_climate_controller.sv
// Self-checking bench for the climate controller with drive and lockout prediction.
`default_nettype none

module tb_dual_bang_bang_climate_controller;
    import dbbcc_pkg::*;

    // One result request: the four actuator drives after a tick.
    typedef struct packed {
        logic heater;
        logic cooler;
        logic ventilator;
        logic humidifier;
    } drive_set_t;

    // Tracks the controller state and queues the drives each accepted sample should produce.
    class climate_drive_model;
        localparam longint FRAC_ONE = 65536;

        logic                      temp_en;
        logic signed [TEMP_W-1:0]  temp_tgt;
        logic                      humid_en;
        logic [HUMID_W-1:0]        humid_tgt;
        logic [FRAC_W-1:0]         on_frac;
        logic [FRAC_W-1:0]         off_frac;
        logic [LOCK_W-1:0]         lock_ticks;

        drive_set_t                drive;
        logic [LOCK_W-1:0]         heater_lock;
        logic [LOCK_W-1:0]         cooler_lock;
        logic [LOCK_W-1:0]         vent_lock;
        logic [LOCK_W-1:0]         humid_lock;

        drive_set_t                expected_drives[$];
        int                        mismatches;

        function new();
            temp_en     = RST_TEMP_ENABLE;
            temp_tgt    = RST_TEMP_TARGET;
            humid_en    = RST_HUMID_ENABLE;
            humid_tgt   = RST_HUMID_TARGET;
            on_frac     = RST_BAND_ON_FRAC;
            off_frac    = RST_BAND_OFF_FRAC;
            lock_ticks  = RST_LOCKOUT_TICKS;
            drive       = '0;
            heater_lock = '0;
            cooler_lock = '0;
            vent_lock   = '0;
            humid_lock  = '0;
            mismatches  = 0;
        endfunction

        // Register write; an unused index leaves everything as it was.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
            case (idx)
                REG_TEMP_ENABLE:   temp_en    = word[0];
                REG_TEMP_TARGET:   temp_tgt   = word[TEMP_W-1:0];
                REG_HUMID_ENABLE:  humid_en   = word[0];
                REG_HUMID_TARGET:  humid_tgt  = word[HUMID_W-1:0];
                REG_BAND_ON_FRAC:  on_frac    = word[FRAC_W-1:0];
                REG_BAND_OFF_FRAC: off_frac   = word[FRAC_W-1:0];
                REG_LOCKOUT_TICKS: lock_ticks = word[LOCK_W-1:0];
                default: ;
            endcase
        endfunction

        // Threshold = floor(target * scale / 65536); the shift rounds toward minus infinity.
        function longint scaled(longint target, longint scale);
            longint prod;
            prod = target * scale;
            return prod >>> 16;
        endfunction

        // One control tick: both hysteresis loops, then the lockout countdown.
        function void take_sample(logic signed [TEMP_W-1:0] t_raw, logic [HUMID_W-1:0] h_raw,
                                  logic fault);
            longint t;
            longint h;
            longint tg;
            longint hg;
            longint on;
            longint off;
            t   = t_raw;
            h   = h_raw;
            tg  = temp_tgt;
            hg  = humid_tgt;
            on  = on_frac;
            off = off_frac;

            // Heater and cooler loop.
            if (!temp_en || fault)
            begin
                drive.heater = 1'b0;
                drive.cooler = 1'b0;
            end
            else
            begin
                if (t > scaled(tg, FRAC_ONE - off) && drive.heater)
                begin
                    drive.heater = 1'b0;
                    cooler_lock  = lock_ticks;
                end
                if (t < scaled(tg, FRAC_ONE + off) && drive.cooler)
                begin
                    drive.cooler = 1'b0;
                    heater_lock  = lock_ticks;
                end
                if (t > scaled(tg, FRAC_ONE + on) && cooler_lock == 0)
                    drive.cooler = 1'b1;
                if (t < scaled(tg, FRAC_ONE - on) && heater_lock == 0)
                    drive.heater = 1'b1;
            end

            // Ventilator and humidifier loop.
            if (!humid_en || fault)
            begin
                drive.ventilator = 1'b0;
                drive.humidifier = 1'b0;
            end
            else
            begin
                if (h < scaled(hg, FRAC_ONE - off) && drive.ventilator)
                begin
                    drive.ventilator = 1'b0;
                    humid_lock       = lock_ticks;
                end
                if (h > scaled(hg, FRAC_ONE + off) && drive.humidifier)
                begin
                    drive.humidifier = 1'b0;
                    vent_lock        = lock_ticks;
                end
                if (h > scaled(hg, FRAC_ONE + on) && vent_lock == 0)
                    drive.ventilator = 1'b1;
                if (h < scaled(hg, FRAC_ONE - on) && humid_lock == 0)
                    drive.humidifier = 1'b1;
            end

            // Counters stop at zero.
            heater_lock -= LOCK_W'(heater_lock != 0);
            cooler_lock -= LOCK_W'(cooler_lock != 0);
            vent_lock   -= LOCK_W'(vent_lock != 0);
            humid_lock  -= LOCK_W'(humid_lock != 0);

            expected_drives.push_back(drive);
        endfunction

        function void check_bit(string field, logic want, logic got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0b, got %0b", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Compare an accepted result request with the oldest expected drive set.
        function void match_drives(drive_set_t got);
            drive_set_t want;
            if (expected_drives.size() == 0)
            begin
                $display("%0t: result expected none, got %b", $time, got);
                mismatches++;
                return;
            end
            want = expected_drives.pop_front();
            check_bit("heater_on", want.heater, got.heater);
            check_bit("cooler_on", want.cooler, got.cooler);
            check_bit("ventilator_on", want.ventilator, got.ventilator);
            check_bit("humidifier_on", want.humidifier, got.humidifier);
        endfunction
    endclass

    localparam int                 NUM_REGS         = int'(REG_LOCKOUT_TICKS) + 1;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG_INDEX = 3'd7;
    localparam int                 NUM_PHASES       = 12;
    localparam int                 PHASE_ITEMS      = 136;
    localparam int                 HOLD_PHASE       = 2;
    localparam int                 DRAIN_PHASE      = 9;
    localparam int                 CYCLE_LIMIT      = 300000;
    localparam int                 TEMP_MIN         = -16384;
    localparam int                 TEMP_MAX         = 16383;
    localparam int                 HUMID_MAX        = 16383;

    logic clk = 1'b0;
    logic rst_n;

    dbbcc_sample_if sample_ch ();
    dbbcc_result_if result_ch ();
    dbbcc_cfg_if    cfg_ch ();

    dual_bang_bang_climate_controller dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    climate_drive_model model = new();

    logic [CFG_DATA_W-1:0] cfg_words [NUM_REGS];
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int cycles;

    always #6 clk = ~clk;

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result ready: a counted hold-off when asked, otherwise random idling.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted result request is checked against the prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            model.match_drives({result_ch.heater_on, result_ch.cooler_on,
                                result_ch.ventilator_on, result_ch.humidifier_on});
    end

    // Offer one sample request and hold it until accepted; valid stays high afterwards.
    task automatic send_sample(int t, int h, logic fault);
        sample_ch.valid        <= 1'b1;
        sample_ch.temp_sample  <= TEMP_W'(t);
        sample_ch.humid_sample <= HUMID_W'(h);
        sample_ch.sensor_fault <= fault;
        do @(posedge clk); while (sample_ch.ready !== 1'b1);
        model.take_sample(TEMP_W'(t), HUMID_W'(h), fault);
    endtask

    task automatic pause_sender(int n);
        sample_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Stop offering samples until every predicted result has come back.
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (model.expected_drives.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= word;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        model.write_reg(idx, word);
    endtask

    // Write all registers, then one write to an index nothing decodes.
    task automatic apply_settings();
        for (int i = 0; i < NUM_REGS; i++)
            write_reg(i[CFG_IDX_W-1:0], cfg_words[i]);
        write_reg(UNUSED_REG_INDEX, 16'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Register set for one random phase; the first two take the extremes, the third fully random words.
    task automatic pick_settings(int phase);
        int on;
        for (int i = 0; i < NUM_REGS; i++)
            cfg_words[i] = 16'($urandom);
        cfg_words[REG_TEMP_ENABLE][0]  = (phase % 5 != 3);
        cfg_words[REG_HUMID_ENABLE][0] = (phase % 4 != 2);
        case (phase)
            0:
            begin
                cfg_words[REG_TEMP_TARGET][TEMP_W-1:0]   = TEMP_W'(-4000);
                cfg_words[REG_HUMID_TARGET][HUMID_W-1:0] = '0;
                cfg_words[REG_BAND_ON_FRAC]              = '0;
                cfg_words[REG_BAND_OFF_FRAC]             = '0;
                cfg_words[REG_LOCKOUT_TICKS][LOCK_W-1:0] = '0;
            end
            1:
            begin
                cfg_words[REG_TEMP_TARGET][TEMP_W-1:0]   = TEMP_W'(12500);
                cfg_words[REG_HUMID_TARGET][HUMID_W-1:0] = HUMID_W'(10000);
                cfg_words[REG_BAND_ON_FRAC]              = 16'hFFFF;
                cfg_words[REG_BAND_OFF_FRAC]             = 16'hFFFF;
                cfg_words[REG_LOCKOUT_TICKS][LOCK_W-1:0] = 8'hFF;
            end
            2: ;
            default:
            begin
                on = $urandom_range(8000);
                cfg_words[REG_TEMP_TARGET][TEMP_W-1:0]   = TEMP_W'($urandom_range(16500) - 4000);
                cfg_words[REG_HUMID_TARGET][HUMID_W-1:0] = HUMID_W'($urandom_range(10000));
                cfg_words[REG_BAND_ON_FRAC]              = 16'(on);
                // Mostly an inner band inside the outer one, sometimes wider.
                cfg_words[REG_BAND_OFF_FRAC] = ($urandom_range(3) == 0) ?
                    16'($urandom_range(12000)) : 16'($urandom_range(on));
                cfg_words[REG_LOCKOUT_TICKS][LOCK_W-1:0] = LOCK_W'($urandom_range(20));
            end
        endcase
    endtask

    // Random samples: mostly slow walks across both hysteresis bands, some raw noise.
    task automatic run_phase(int phase, int count);
        logic signed [TEMP_W-1:0] tgt15;
        int     t_mid;
        int     h_mid;
        int     t_span;
        int     h_span;
        int     t_walk;
        int     h_walk;
        int     t_step;
        int     h_step;
        longint widest;
        tgt15  = cfg_words[REG_TEMP_TARGET][TEMP_W-1:0];
        t_mid  = tgt15;
        h_mid  = cfg_words[REG_HUMID_TARGET][HUMID_W-1:0];
        widest = (cfg_words[REG_BAND_ON_FRAC] > cfg_words[REG_BAND_OFF_FRAC]) ?
                 cfg_words[REG_BAND_ON_FRAC] : cfg_words[REG_BAND_OFF_FRAC];
        t_span = int'(((t_mid < 0 ? -t_mid : t_mid) * widest) >>> 16) + 8;
        h_span = int'((h_mid * widest) >>> 16) + 8;
        t_step = t_span / 4 + 1;
        h_step = h_span / 4 + 1;
        t_walk = t_mid;
        h_walk = h_mid;
        for (int n = 0; n < count; n++)
        begin
            if (phase == HOLD_PHASE && n == 40)
                hold_left = 60;
            if (phase == DRAIN_PHASE && n == count / 2)
                wait_drained();
            if ($urandom_range(99) < 15)
            begin
                send_sample(TEMP_W'($urandom), HUMID_W'($urandom), 1'($urandom));
            end
            else
            begin
                t_walk += int'($urandom_range(2 * t_step)) - t_step;
                h_walk += int'($urandom_range(2 * h_step)) - h_step;
                t_walk = (t_walk < t_mid - 2 * t_span) ? t_mid - 2 * t_span : t_walk;
                t_walk = (t_walk > t_mid + 2 * t_span) ? t_mid + 2 * t_span : t_walk;
                t_walk = (t_walk < TEMP_MIN) ? TEMP_MIN : (t_walk > TEMP_MAX) ? TEMP_MAX : t_walk;
                h_walk = (h_walk < h_mid - 2 * h_span) ? h_mid - 2 * h_span : h_walk;
                h_walk = (h_walk > h_mid + 2 * h_span) ? h_mid + 2 * h_span : h_walk;
                h_walk = (h_walk < 0) ? 0 : (h_walk > HUMID_MAX) ? HUMID_MAX : h_walk;
                send_sample(t_walk, h_walk, $urandom_range(99) < 4);
            end
            if ($urandom_range(99) < send_idle_pct)
                pause_sender($urandom_range(3, 1));
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        send_idle_pct          = 0;
        recv_idle_pct          = 0;
        sample_ch.valid        = 1'b0;
        sample_ch.temp_sample  = '0;
        sample_ch.humid_sample = '0;
        sample_ch.sensor_fault = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = '0;
        cfg_words[REG_TEMP_ENABLE]   = 16'(RST_TEMP_ENABLE);
        cfg_words[REG_TEMP_TARGET]   = 16'(RST_TEMP_TARGET);
        cfg_words[REG_HUMID_ENABLE]  = 16'(RST_HUMID_ENABLE);
        cfg_words[REG_HUMID_TARGET]  = 16'(RST_HUMID_TARGET);
        cfg_words[REG_BAND_ON_FRAC]  = RST_BAND_ON_FRAC;
        cfg_words[REG_BAND_OFF_FRAC] = RST_BAND_OFF_FRAC;
        cfg_words[REG_LOCKOUT_TICKS] = 16'(RST_LOCKOUT_TICKS);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: heater on and off, cooler held by the lockout,
        // a sensor fault, then the sample extremes.
        send_sample(2700, 5000, 1'b0);
        send_sample(2760, 5000, 1'b0);
        send_sample(2900, 5000, 1'b0);
        send_sample(2900, 5000, 1'b1);
        send_sample(TEMP_MIN, 0, 1'b0);
        send_sample(TEMP_MAX, HUMID_MAX, 1'b0);
        wait_drained();

        // Humidity loop on with zero lockout: the opposite actuator may start in the same tick.
        cfg_words[REG_HUMID_ENABLE]  = 16'd1;
        cfg_words[REG_LOCKOUT_TICKS] = '0;
        apply_settings();
        send_sample(2800, 0, 1'b0);
        send_sample(2800, HUMID_MAX, 1'b0);
        send_sample(2800, 4000, 1'b0);
        send_sample(2800, 5000, 1'b1);
        send_sample(2800, 4000, 1'b0);
        wait_drained();

        // Negative target: the outer bands cross, so heater and cooler can both run.
        cfg_words[REG_TEMP_TARGET]   = 16'(-4000);
        cfg_words[REG_BAND_ON_FRAC]  = 16'd6553;
        cfg_words[REG_BAND_OFF_FRAC] = '0;
        cfg_words[REG_LOCKOUT_TICKS] = 16'd3;
        apply_settings();
        send_sample(-4000, 5000, 1'b0);
        send_sample(-4000, 5000, 1'b0);
        send_sample(-3000, 5000, 1'b0);
        send_sample(-5000, 5000, 1'b0);
        wait_drained();

        // Both loops disabled: all drives forced off.
        cfg_words[REG_TEMP_ENABLE]  = '0;
        cfg_words[REG_HUMID_ENABLE] = '0;
        apply_settings();
        send_sample(TEMP_MIN, 0, 1'b0);
        send_sample(TEMP_MAX, HUMID_MAX, 1'b0);
        wait_drained();

        // Random phases: sender-light idling, then receiver-light, then none.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct = (phase < 4) ? 17 : (phase < 8) ? 59 : 0;
            recv_idle_pct = (phase < 4) ? 59 : (phase < 8) ? 17 : 0;
            pick_settings(phase);
            apply_settings();
            run_phase(phase, PHASE_ITEMS);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (model.mismatches == 0 && model.expected_drives.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/dbbcc_pkg.sv
hdl/dbbcc_if.sv
hdl/dual_bang_bang_climate_controller.sv
bench/tb_dual_bang_bang_climate_controller.sv
